FILE: sv/lcdw_pkg.sv
`default_nettype none

package lcdw_pkg;

    typedef enum logic [2:0] {
        OP_PUT_CHAR   = 3'd0,
        OP_SET_CURSOR = 3'd1,
        OP_COMMAND    = 3'd2,
        OP_DATA       = 3'd3,
        OP_NIBBLE     = 3'd4
    } opcode_t;

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;

    localparam logic [7:0] DDRAM_SET = 8'h80;
    localparam logic [7:0] E_DROP    = 8'h01;

    // per-word position inside one byte transfer
    typedef enum logic [4:0] {
        STEP_RS      = 5'b00001,
        STEP_HI      = 5'b00010,
        STEP_HI_DROP = 5'b00100,
        STEP_LO      = 5'b01000,
        STEP_LO_DROP = 5'b10000
    } step_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] ROW_BASE [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

    // one byte or nibble transfer handed from the front to the back
    typedef struct packed {
        logic       nib;
        logic       rs;
        logic [7:0] value;
        logic       last;
    } job_t;

    function automatic logic [7:0] set_cmd(input logic [7:0] c, input logic [1:0] r);
        set_cmd = DDRAM_SET | (c + ROW_BASE[r]);
    endfunction

    function automatic logic [7:0] nib_word(input logic [3:0] n, input logic rs);
        nib_word = {rs, 1'b0, 1'b1, n[0], n[1], n[2], n[3], 1'b1};
    endfunction

endpackage

`default_nettype wire

FILE: sv/char_lcd_nibble_write_sequencer.sv
// 4-bit character lcd write sequencer: display requests in, expander port words out.
// input side: queue style, a word is taken when push is high and full is low;
//   opcode selects put char, set cursor, command byte, data byte or raw nibble.
// output side: queue style, the oldest port word sits on port_byte/last while
//   empty is low and leaves when pop is high; last marks the final word of a request.
// a byte becomes 5 words (rs, high nibble with e, e drop, low nibble with e, e drop),
//   a raw nibble 2 words, a put char that wraps the line 10 words, nul and unused
//   opcodes none.
// a taken request passes the front hold register, the transfer queue and the output word register.
// the back end sends one word per cycle while pop stays high and the transfer queue is not
//   empty; the front end takes a request per cycle until the 4-deep transfer queue fills
//   or a wrapping put char holds the input.
// the front end owns the cursor; a put char with a line wrap holds the input until
//   both transfers are queued.
// reset clears the cursor to column 0, row 0 and empties every stage.
// a stalled pop holds the output word; the queue then fills and full backs up input.
`default_nettype none

module char_lcd_nibble_write_sequencer #(
    parameter int NUM_COLS = 16,
    parameter int NUM_ROWS = 2
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [2:0] opcode,
    input  wire logic [7:0] byte_value,
    input  wire logic [5:0] col,
    input  wire logic [2:0] row,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      port_byte,
    output logic            last
);
    import lcdw_pkg::*;

    logic q_full;
    logic q_empty;
    logic q_wr;
    logic q_rd;
    job_t wr_job;
    job_t rd_job;

    lcdw_front #(
        .NUM_COLS (NUM_COLS),
        .NUM_ROWS (NUM_ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .opcode     (opcode),
        .byte_value (byte_value),
        .col        (col),
        .row        (row),
        .q_full     (q_full),
        .q_wr       (q_wr),
        .q_job      (wr_job)
    );

    lcdw_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_job  (wr_job),
        .q_full  (q_full),
        .rd      (q_rd),
        .rd_job  (rd_job),
        .q_empty (q_empty)
    );

    lcdw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_job     (rd_job),
        .q_rd      (q_rd),
        .pop       (pop),
        .empty     (empty),
        .port_byte (port_byte),
        .last      (last)
    );

endmodule

`default_nettype wire

FILE: sv/lcdw_front.sv
`default_nettype none

module lcdw_front #(
    parameter int NUM_COLS = 16,
    parameter int NUM_ROWS = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [2:0]       opcode,
    input  wire logic [7:0]       byte_value,
    input  wire logic [5:0]       col,
    input  wire logic [2:0]       row,
    input  wire logic             q_full,
    output logic                  q_wr,
    output lcdw_pkg::job_t        q_job
);
    import lcdw_pkg::*;

    logic       hold_valid_reg, hold_valid_next;
    logic [2:0] op_reg;
    logic [7:0] bv_reg;
    logic [5:0] col_reg;
    logic [2:0] row_reg;
    logic       wrap_done_reg, wrap_done_next;
    logic [7:0] cursor_col_reg, cursor_col_next;
    logic [1:0] cursor_row_reg, cursor_row_next;
    logic       done;
    logic       accept;
    logic       is_char;
    logic       need_wrap;
    logic [1:0] r;

    function automatic logic [1:0] clamp_row(input logic [2:0] rr);
        clamp_row = (rr >= 3'(NUM_ROWS)) ? 2'd0 : rr[1:0];
    endfunction

    assign is_char   = (op_reg == OP_PUT_CHAR) && (bv_reg != CHAR_NUL);
    assign need_wrap = is_char && (cursor_col_reg >= 8'(NUM_COLS)) && !wrap_done_reg;

    always_comb
    begin
        q_wr            = 1'b0;
        q_job           = '0;
        done            = 1'b0;
        r               = 2'd0;
        wrap_done_next  = wrap_done_reg;
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        if (hold_valid_reg && !q_full)
        begin
            if (need_wrap)
            begin
                // column limit reached: move to column 1 of the next row first
                r               = clamp_row({1'b0, cursor_row_reg} + 3'd1);
                cursor_col_next = 8'd1;
                cursor_row_next = r;
                q_wr            = 1'b1;
                q_job           = '{nib: 1'b0, rs: 1'b0, value: set_cmd(8'd1, r), last: 1'b0};
                wrap_done_next  = 1'b1;
            end
            else
            begin
                done           = 1'b1;
                wrap_done_next = 1'b0;
                unique case (op_reg)
                    OP_PUT_CHAR:
                    begin
                        if (bv_reg == CHAR_NUL)
                        begin
                            q_wr = 1'b0;
                        end
                        else if (bv_reg == CHAR_LF)
                        begin
                            r               = clamp_row({1'b0, cursor_row_reg} + 3'd1);
                            cursor_col_next = 8'd1;
                            cursor_row_next = r;
                            q_wr            = 1'b1;
                            q_job = '{nib: 1'b0, rs: 1'b0, value: set_cmd(8'd1, r), last: 1'b1};
                        end
                        else if (bv_reg == CHAR_CR)
                        begin
                            r               = clamp_row({1'b0, cursor_row_reg});
                            cursor_col_next = 8'd0;
                            cursor_row_next = r;
                            q_wr            = 1'b1;
                            q_job = '{nib: 1'b0, rs: 1'b0, value: set_cmd(8'd0, r), last: 1'b1};
                        end
                        else
                        begin
                            cursor_col_next = cursor_col_reg + 8'd1;
                            q_wr            = 1'b1;
                            q_job = '{nib: 1'b0, rs: 1'b1, value: bv_reg, last: 1'b1};
                        end
                    end
                    OP_SET_CURSOR:
                    begin
                        r               = clamp_row(row_reg);
                        cursor_col_next = {2'b00, col_reg};
                        cursor_row_next = r;
                        q_wr            = 1'b1;
                        q_job = '{nib: 1'b0, rs: 1'b0, value: set_cmd({2'b00, col_reg}, r),
                                  last: 1'b1};
                    end
                    OP_COMMAND:
                    begin
                        q_wr  = 1'b1;
                        q_job = '{nib: 1'b0, rs: 1'b0, value: bv_reg, last: 1'b1};
                    end
                    OP_DATA:
                    begin
                        q_wr  = 1'b1;
                        q_job = '{nib: 1'b0, rs: 1'b1, value: bv_reg, last: 1'b1};
                    end
                    OP_NIBBLE:
                    begin
                        q_wr  = 1'b1;
                        q_job = '{nib: 1'b1, rs: 1'b0, value: {4'h0, bv_reg[3:0]}, last: 1'b1};
                    end
                    default:
                    begin
                        q_wr = 1'b0;
                    end
                endcase
            end
        end
    end

    assign full   = hold_valid_reg && !done;
    assign accept = push && !full;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (done)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            wrap_done_reg  <= 1'b0;
            cursor_col_reg <= 8'd0;
            cursor_row_reg <= 2'd0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            wrap_done_reg  <= wrap_done_next;
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= opcode;
            bv_reg  <= byte_value;
            col_reg <= col;
            row_reg <= row;
        end
    end

endmodule

`default_nettype wire

FILE: sv/lcdw_queue.sv
`default_nettype none

module lcdw_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr,
    input  wire lcdw_pkg::job_t  wr_job,
    output logic                 q_full,
    input  wire logic            rd,
    output lcdw_pkg::job_t       rd_job,
    output logic                 q_empty
);
    import lcdw_pkg::*;

    job_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                do_wr;
    logic                do_rd;

    assign q_full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rd_job  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

`default_nettype wire

FILE: sv/lcdw_back.sv
`default_nettype none

module lcdw_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_empty,
    input  wire lcdw_pkg::job_t  q_job,
    output logic                 q_rd,
    input  wire logic            pop,
    output logic                 empty,
    output logic [7:0]           port_byte,
    output logic                 last
);
    import lcdw_pkg::*;

    step_t      step_reg, step_next;
    step_t      cur_step;
    step_t      adv_step;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] port_byte_reg;
    logic       last_reg;
    logic [7:0] word;
    logic       load;

    // a nibble transfer skips the rs word, the high nibble and its e drop
    assign cur_step = (step_reg == STEP_RS && q_job.nib) ? STEP_LO : step_reg;
    assign load     = !q_empty && (!out_valid_reg || pop);
    assign q_rd     = load && (cur_step == STEP_LO_DROP);

    always_comb
    begin
        unique case (cur_step)
            STEP_RS:      word = {q_job.rs, 6'b000000, 1'b1};
            STEP_HI:      word = nib_word(q_job.value[7:4], q_job.rs);
            STEP_HI_DROP: word = E_DROP;
            STEP_LO:      word = nib_word(q_job.value[3:0], q_job.rs);
            STEP_LO_DROP: word = E_DROP;
            default:      word = E_DROP;
        endcase
    end

    always_comb
    begin
        unique case (cur_step)
            STEP_RS:      adv_step = STEP_HI;
            STEP_HI:      adv_step = STEP_HI_DROP;
            STEP_HI_DROP: adv_step = STEP_LO;
            STEP_LO:      adv_step = STEP_LO_DROP;
            STEP_LO_DROP: adv_step = STEP_RS;
            default:      adv_step = STEP_RS;
        endcase
    end

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            step_next      = adv_step;
            out_valid_next = 1'b1;
        end
        else if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_RS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            port_byte_reg <= word;
            last_reg      <= q_job.last && (cur_step == STEP_LO_DROP);
        end
    end

    assign empty     = !out_valid_reg;
    assign port_byte = port_byte_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire
